>>> design/ssnf_pkg.sv
package ssnf_pkg;

	localparam int DIGIT_COUNT_DEF = 8;
	// Wide enough for print position plus field width plus a sign digit.
	localparam int CNT_W = 6;

	localparam logic [7:0] SEG_MINUS = 8'h40;
	localparam logic [7:0] SEG_BLANK = 8'h00;
	localparam logic [7:0] DOT_BIT = 8'h80;

	typedef enum logic [1:0] {
		ACT_PRINT_U = 2'd0,
		ACT_PRINT_S = 2'd1,
		ACT_DOTS    = 2'd2,
		ACT_RAW     = 2'd3
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] value_bits;
		logic [4:0]  radix;
		logic [3:0]  field_digits;
		logic [3:0]  pad_digits;
		logic [2:0]  digit_index;
		logic [7:0]  segment_bits;
		logic [7:0]  new_dot_mask;
	} in_t;

	typedef struct packed {
		logic [3:0] reg_address;
		logic [7:0] reg_data;
		logic       last_write;
	} out_t;

	// Classified command as it waits in the queue.
	typedef struct packed {
		action_t     act;
		logic [31:0] mag;
		logic        neg;
		logic [4:0]  radix;
		logic [3:0]  field;
		logic [3:0]  pad;
		logic [2:0]  pos;
		logic [2:0]  index;
		logic [7:0]  seg;
		logic [7:0]  dots;
	} cmd_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		unique case (d)
			4'h0: g = 8'h3F;
			4'h1: g = 8'h06;
			4'h2: g = 8'h5B;
			4'h3: g = 8'h4F;
			4'h4: g = 8'h66;
			4'h5: g = 8'h6D;
			4'h6: g = 8'h7D;
			4'h7: g = 8'h07;
			4'h8: g = 8'h7F;
			4'h9: g = 8'h6F;
			4'hA: g = 8'h77;
			4'hB: g = 8'h7C;
			4'hC: g = 8'h39;
			4'hD: g = 8'h5E;
			4'hE: g = 8'h79;
			default: g = 8'h71;
		endcase
		return g;
	endfunction

endpackage

>>> design/ssnf_div.sv
module ssnf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [4:0]  divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quot,
	output logic [3:0]  rem
);
	logic [31:0] work_q;
	logic [4:0]  dvs_q;
	logic [3:0]  rem_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [3:0]  r_nxt;
	logic [7:0]  qbits;

	// Restoring division, eight quotient bits per cycle.
	always_comb begin
		logic [4:0] r5;
		logic [3:0] r;
		r = rem_q;
		qbits = '0;
		for (int k = 0; k < 8; k++) begin
			r5 = {r, work_q[31 - k]};
			if (r5 >= dvs_q) begin
				r5 = r5 - dvs_q;
				qbits[7 - k] = 1'b1;
			end
			r = r5[3:0];
		end
		r_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[23:0], qbits};
			rem_q <= r_nxt;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = work_q;
	assign rem = rem_q;
endmodule

>>> design/ssnf_fifo.sv
module ssnf_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ssnf_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output ssnf_pkg::cmd_t head
);
	import ssnf_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	assign full = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head = mem_q[rd_q];

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
endmodule

>>> design/ssnf_front.sv
module ssnf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ssnf_pkg::in_t  in_data,
	input  logic [2:0]     print_pos,
	output logic           push,
	output ssnf_pkg::cmd_t push_data,
	input  logic           full
);
	import ssnf_pkg::*;

	cmd_t cmd_s1;
	logic vld_s1;
	cmd_t cls;

	always_comb begin
		cls.act = in_data.action;
		cls.neg = (in_data.action == ACT_PRINT_S) && in_data.value_bits[31];
		cls.mag = cls.neg ? (32'd0 - in_data.value_bits) : in_data.value_bits;
		if (in_data.radix < 5'd2)
			cls.radix = 5'd2;
		else if (in_data.radix > 5'd16)
			cls.radix = 5'd16;
		else
			cls.radix = in_data.radix;
		cls.field = in_data.field_digits;
		cls.pad = (in_data.action == ACT_PRINT_S) ? 4'd1 : in_data.pad_digits;
		cls.pos = print_pos;
		cls.index = in_data.digit_index;
		cls.seg = in_data.segment_bits;
		cls.dots = in_data.new_dot_mask;
	end

	assign push = vld_s1 && !full;
	assign in_ready = !vld_s1 || !full;
	assign push_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			cmd_s1 <= cls;
	end
endmodule

>>> design/ssnf_back.sv
module ssnf_back #(
	parameter int DIGIT_COUNT = ssnf_pkg::DIGIT_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  ssnf_pkg::cmd_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output ssnf_pkg::out_t out_data
);
	import ssnf_pkg::*;

	localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [CNT_W-1:0] DC_C = CNT_W'(DIGIT_COUNT);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DIV     = 6'b000010,
		S_PLAN    = 6'b000100,
		S_WRITE   = 6'b001000,
		S_EXTRA   = 6'b010000,
		S_REFRESH = 6'b100000
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [7:0]       store_q [DIGIT_COUNT];
	logic [3:0]       rem_q [DIGIT_COUNT];
	logic [7:0]       dot_mask_q;
	logic [3:0]       step_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] zcnt_q;
	logic [3:0]       lim_q;
	logic             ovf_q;
	logic             has_extra_q;
	logic [CNT_W-1:0] extra_pos_q;
	logic [7:0]       extra_seg_q;
	logic             out_valid_q;
	out_t             out_q;

	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic [31:0]      div_quot;
	logic [3:0]       div_rem;
	logic [31:0]      div_dividend;
	logic [4:0]       div_divisor;
	logic             div_more;

	logic             can_emit;
	logic             emit_fire;
	logic [CNT_W-1:0] wr_pos;
	logic [7:0]       wr_seg;
	logic             wr_last;
	logic [CNT_W-1:0] addr_full;
	logic [CNT_W-1:0] step_w;
	logic [CNT_W-1:0] n_w;
	logic             ovf_w;
	logic [CNT_W-1:0] room_w;
	logic [CNT_W-1:0] field_w;
	logic [3:0]       lim_w;

	ssnf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign pop = (state_q == S_IDLE) && head_valid;
	assign div_more = (div_quot != 32'd0) && (CNT_W'(step_q) != DC_C - CNT_W'(1));
	assign div_start = (pop && (head.act == ACT_PRINT_U || head.act == ACT_PRINT_S))
		|| (state_q == S_DIV && div_done && div_more);
	assign div_dividend = (state_q == S_IDLE) ? head.mag : div_quot;
	assign div_divisor = (state_q == S_IDLE) ? head.radix : cmd_q.radix;

	assign step_w = CNT_W'(step_q);
	assign field_w = CNT_W'(cmd_q.field);
	assign n_w = cnt_q + CNT_W'(cmd_q.act == ACT_PRINT_S);
	assign ovf_w = (n_w > field_w) || (CNT_W'(cmd_q.pos) + n_w > DC_C);
	assign room_w = DC_C - CNT_W'(cmd_q.pos);
	assign lim_w = (field_w < room_w) ? cmd_q.field : room_w[3:0];

	always_comb begin
		wr_pos = step_w;
		wr_seg = store_q[step_q[PW-1:0]];
		wr_last = step_w == DC_C - CNT_W'(1);
		unique case (state_q)
			S_WRITE: begin
				wr_pos = CNT_W'(cmd_q.pos) + step_w;
				wr_last = (step_q == lim_q - 4'd1) && !has_extra_q;
				if (ovf_q)
					wr_seg = SEG_MINUS;
				else if (step_w >= zcnt_q && step_q >= cmd_q.pad)
					wr_seg = SEG_BLANK;
				else if (step_w < cnt_q)
					wr_seg = glyph(rem_q[step_q[PW-1:0]]);
				else
					wr_seg = glyph(4'd0);
			end
			S_EXTRA: begin
				wr_pos = extra_pos_q;
				wr_seg = extra_seg_q;
				wr_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign can_emit = !out_valid_q || out_ready;
	assign emit_fire = can_emit
		&& (state_q == S_WRITE || state_q == S_EXTRA || state_q == S_REFRESH);
	assign addr_full = DC_C - CNT_W'(1) - wr_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			dot_mask_q <= '0;
			step_q <= '0;
			for (int k = 0; k < DIGIT_COUNT; k++)
				store_q[k] <= '0;
		end else begin
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (emit_fire && state_q != S_REFRESH)
				store_q[wr_pos[PW-1:0]] <= wr_seg;

			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (head_valid) begin
						unique case (head.act)
							ACT_PRINT_U, ACT_PRINT_S: state_q <= S_DIV;
							ACT_DOTS: begin
								dot_mask_q <= head.dots;
								state_q <= S_REFRESH;
							end
							default: begin
								if (CNT_W'(head.index) < DC_C)
									state_q <= S_EXTRA;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_more)
							step_q <= step_q + 4'd1;
						else
							state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					step_q <= '0;
					if (lim_w == 4'd0)
						state_q <= S_IDLE;
					else
						state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (emit_fire) begin
						step_q <= step_q + 4'd1;
						if (wr_last)
							state_q <= S_IDLE;
						else if (step_q == lim_q - 4'd1)
							state_q <= S_EXTRA;
					end
				end
				S_EXTRA: begin
					if (emit_fire)
						state_q <= S_IDLE;
				end
				S_REFRESH: begin
					if (emit_fire) begin
						step_q <= step_q + 4'd1;
						if (wr_last)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
			extra_pos_q <= CNT_W'(head.index);
			extra_seg_q <= head.seg;
			has_extra_q <= 1'b1;
		end
		if (state_q == S_DIV && div_done) begin
			rem_q[step_q[PW-1:0]] <= div_rem;
			if (!div_more) begin
				cnt_q <= step_w + CNT_W'(1) + CNT_W'(div_quot != 32'd0);
				zcnt_q <= (cmd_q.mag == 32'd0) ? '0
					: step_w + CNT_W'(1) + CNT_W'(div_quot != 32'd0);
			end
		end
		if (state_q == S_PLAN) begin
			ovf_q <= ovf_w;
			lim_q <= lim_w;
			// Unless the print overflows, a negative print ends with its minus, a positive one blanks the sign slot.
			if (cmd_q.act == ACT_PRINT_S && !ovf_w) begin
				if (cmd_q.neg) begin
					extra_pos_q <= CNT_W'(cmd_q.pos) + n_w - CNT_W'(1);
					extra_seg_q <= SEG_MINUS;
					has_extra_q <= 1'b1;
				end else begin
					extra_pos_q <= CNT_W'(cmd_q.pos) + field_w;
					extra_seg_q <= SEG_BLANK;
					has_extra_q <= CNT_W'(cmd_q.pos) + field_w < DC_C;
				end
			end else begin
				has_extra_q <= 1'b0;
			end
		end
		if (emit_fire) begin
			out_q.reg_address <= {addr_full[2:0], 1'b0};
			out_q.reg_data <= wr_seg
				| ((wr_pos < CNT_W'(8) && dot_mask_q[wr_pos[2:0]]) ? DOT_BIT : 8'h00);
			out_q.last_write <= wr_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_pos_on_display: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> wr_pos < DC_C) else $error("write to a digit off the display");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLAN |-> cnt_q >= CNT_W'(1) && cnt_q <= DC_C + CNT_W'(1))
		else $error("digit count out of range");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != S_IDLE || $past(head.act) == ACT_RAW)
		else $error("command taken without work");
endmodule

>>> design/seven_segment_number_formatter.sv
// Formats numbers for a seven-segment display and emits driver register writes, one
// transaction per digit, the final one marked by last_write. A print takes one radix
// division per counted digit in a single iterative divider, at most DIGIT_COUNT of them,
// then up to DIGIT_COUNT + 1 register writes. A dot refresh writes all DIGIT_COUNT digits,
// a raw segment write one. A two-entry command queue lets new transactions be taken while
// writes drain. The user must write print_position through cfg_we and cfg_wdata only
// while idle; the block itself does not enforce this.
module seven_segment_number_formatter #(
	parameter int DIGIT_COUNT = ssnf_pkg::DIGIT_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ssnf_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ssnf_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_wdata
);
	import ssnf_pkg::*;

	logic [2:0] print_pos_q;
	logic       push;
	cmd_t       push_data;
	logic       full;
	logic       pop;
	logic       head_valid;
	cmd_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			print_pos_q <= '0;
		else if (cfg_we && CNT_W'(cfg_wdata) < CNT_W'(DIGIT_COUNT))
			print_pos_q <= cfg_wdata;
	end

	ssnf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.print_pos (print_pos_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	ssnf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ssnf_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);
endmodule
